@@ hdl/cv2d_pkg.sv @@
// shared types and codes for the sliding-window 2d convolution block
// no dependencies; compiled first
`default_nettype none
package cv2d_pkg;

	typedef enum logic [0:0] {
		OP_COEF  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_KERNEL_HALF  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam int unsigned COEF_IDX_W = 8;

	typedef struct packed {
		op_t                operation;
		logic        [3:0]  coef_row;
		logic        [3:0]  coef_col;
		logic signed [15:0] coef_value;
		logic signed [15:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic        [9:0]  out_row;
		logic        [9:0]  out_col;
		logic signed [39:0] value;
		logic               frame_last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  kernel_half;
		logic [10:0] image_width;
		logic [10:0] image_height;
	} cfg_t;

	typedef enum logic [0:0] {
		JOB_COEF  = 1'b0,
		JOB_PIXEL = 1'b1
	} job_kind_t;

	// classified request between front and back
	typedef struct packed {
		job_kind_t               kind;
		logic [COEF_IDX_W-1:0]   coef_idx;
		logic signed [15:0]      sample;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

@@ hdl/cv2d_if.sv @@
// valid/ready channel interfaces: pixel/coefficient input, result output, configuration
// depends on cv2d_pkg
`default_nettype none
interface cv2d_in_if;
	logic               valid;
	logic               ready;
	cv2d_pkg::in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface cv2d_out_if;
	logic                valid;
	logic                ready;
	cv2d_pkg::out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface cv2d_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hdl/cv2d_front.sv @@
// front end: configuration registers, request intake and classification
// depends on cv2d_pkg and cv2d_if
`default_nettype none
module cv2d_front #(
	parameter int unsigned MAX_KERNEL_SIZE = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	cv2d_in_if.sink              pix_in,
	cv2d_cfg_if.sink             cfg,
	input  wire logic            q_ready,
	output logic                 q_push,
	output cv2d_pkg::job_t       q_job,
	output cv2d_pkg::cfg_t       cfg_regs
);
	import cv2d_pkg::*;

	cfg_t cfg_q;
	logic coef_ok;
	logic accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_half  <= 3'd1;
			cfg_q.image_width  <= 11'd1024;
			cfg_q.image_height <= 11'd1024;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_KERNEL_HALF:  cfg_q.kernel_half  <= cfg.wdata[2:0];
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg.wdata;
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign cfg_regs = cfg_q;

	assign pix_in.ready = q_ready;
	assign accept = pix_in.valid && q_ready;
	assign coef_ok = (32'(pix_in.item.coef_row) < MAX_KERNEL_SIZE)
		&& (32'(pix_in.item.coef_col) < MAX_KERNEL_SIZE);

	// out-of-range coefficient loads are taken and dropped here
	assign q_push = accept && ((pix_in.item.operation == OP_PIXEL) || coef_ok);

	always_comb begin
		q_job.kind     = (pix_in.item.operation == OP_PIXEL) ? JOB_PIXEL : JOB_COEF;
		q_job.coef_idx = COEF_IDX_W'(32'(pix_in.item.coef_row) * MAX_KERNEL_SIZE
			+ 32'(pix_in.item.coef_col));
		q_job.sample   = (pix_in.item.operation == OP_PIXEL) ? pix_in.item.pixel
			: pix_in.item.coef_value;
	end
endmodule
`default_nettype wire

@@ hdl/cv2d_queue.sv @@
// two-entry request queue between front and back
// depends on cv2d_pkg
`default_nettype none
module cv2d_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  cv2d_pkg::job_t       push_job,
	output logic                 ready,
	input  wire logic            pop,
	output logic                 valid,
	output cv2d_pkg::job_t       head
);
	import cv2d_pkg::*;

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/cv2d_back.sv @@
// back end: line store, coefficient store, serial multiply-accumulate, result register
// depends on cv2d_pkg and cv2d_if
`default_nettype none
module cv2d_back #(
	parameter int unsigned MAX_KERNEL_SIZE  = 9,
	parameter int unsigned MAX_IMAGE_WIDTH  = 1024,
	parameter int unsigned MAX_IMAGE_HEIGHT = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  cv2d_pkg::cfg_t       cfg_regs,
	input  wire logic            q_valid,
	input  cv2d_pkg::job_t       q_head,
	output logic                 q_pop,
	cv2d_out_if.source           res_out
);
	import cv2d_pkg::*;

	localparam int unsigned K    = MAX_KERNEL_SIZE;
	localparam int unsigned HMAX = (K - 1) / 2;
	localparam int unsigned SW   = $clog2(K);
	localparam int unsigned TW   = $clog2(K);
	localparam int unsigned CW   = $clog2(MAX_IMAGE_WIDTH);
	localparam int unsigned RW   = $clog2(MAX_IMAGE_HEIGHT);
	localparam int unsigned CIW  = $clog2(K * K);

	// storage
	logic signed [15:0] line_mem [K][MAX_IMAGE_WIDTH];
	logic signed [15:0] coef_mem [K * K];
	logic [K*K-1:0]     coef_vld_q;

	// position state
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [SW-1:0] slot_q;

	// job state
	back_state_t   st_q, st_d;
	logic [TW-1:0] span_q, k1_q, k2_q;
	logic [SW-1:0] rd_slot_q;
	logic [CW-1:0] rd_col_q, col0_q;
	logic [9:0]    orow_q, ocol_q;
	logic          last_q;
	logic signed [39:0] acc_q;

	// mac pipeline
	logic               v_s1, fin_s1, cok_s1;
	logic signed [15:0] pix_s1, coef_s1;
	logic               v_s2, fin_s2;
	logic signed [31:0] prod_s2;

	out_item_t res_q;
	logic      res_v_q;

	// clamped configuration
	logic [2:0]    h_c;
	logic [15:0]   w16, ht16, r16, c16, h16, span16;
	logic [TW-1:0] span_c;
	logic          emit;
	logic          issue, tap_last;
	logic          start;
	logic [15:0]   cidx;

	always_comb begin
		if (cfg_regs.kernel_half == 3'd0) h_c = 3'd1;
		else if (32'(cfg_regs.kernel_half) > HMAX) h_c = 3'(HMAX);
		else h_c = cfg_regs.kernel_half;
		if (cfg_regs.image_width == 11'd0) w16 = 16'd1;
		else if (32'(cfg_regs.image_width) > MAX_IMAGE_WIDTH) w16 = 16'(MAX_IMAGE_WIDTH);
		else w16 = 16'(cfg_regs.image_width);
		if (cfg_regs.image_height == 11'd0) ht16 = 16'd1;
		else if (32'(cfg_regs.image_height) > MAX_IMAGE_HEIGHT) ht16 = 16'(MAX_IMAGE_HEIGHT);
		else ht16 = 16'(cfg_regs.image_height);
		h16    = 16'(h_c);
		span16 = {h16[14:0], 1'b0};
		span_c = TW'(span16);
		r16    = 16'(row_q);
		c16    = 16'(col_q);
		emit   = (r16 >= span16) && (c16 >= span16) && (r16 < ht16) && (c16 < w16);
	end

	assign q_pop    = (st_q == BK_IDLE) && q_valid;
	assign start    = q_pop && (q_head.kind == JOB_PIXEL) && emit;
	assign issue    = (st_q == BK_RUN);
	assign tap_last = (k1_q == span_q) && (k2_q == span_q);
	assign cidx     = 16'(k1_q) * 16'(K) + 16'(k2_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE:  if (start) st_d = BK_RUN;
			BK_RUN:   if (tap_last) st_d = BK_DRAIN;
			BK_DRAIN: if (v_s2 && fin_s2) st_d = BK_DONE;
			BK_DONE:  if (!res_v_q) st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == JOB_PIXEL) begin
			line_mem[slot_q][col_q] <= q_head.sample;
		end
		pix_s1 <= line_mem[rd_slot_q][rd_col_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == JOB_COEF) begin
			coef_mem[CIW'(q_head.coef_idx)] <= q_head.sample;
		end
		coef_s1 <= coef_mem[CIW'(cidx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			cok_s1     <= 1'b0;
		end else begin
			if (q_pop && q_head.kind == JOB_COEF) coef_vld_q[CIW'(q_head.coef_idx)] <= 1'b1;
			cok_s1 <= coef_vld_q[CIW'(cidx)];
		end
	end

	// position counters and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
			v_s1   <= 1'b0;
			fin_s1 <= 1'b0;
			v_s2   <= 1'b0;
			fin_s2 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (q_pop && q_head.kind == JOB_PIXEL) begin
				if (c16 + 16'd1 >= w16) begin
					col_q <= '0;
					if (r16 + 16'd1 >= ht16) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= RW'(r16 + 16'd1);
						slot_q <= (32'(slot_q) == K - 1) ? '0 : SW'(32'(slot_q) + 1);
					end
				end else begin
					col_q <= CW'(c16 + 16'd1);
				end
			end
			v_s1   <= issue;
			fin_s1 <= issue && tap_last;
			v_s2   <= v_s1;
			fin_s2 <= fin_s1;
			if (res_out.valid && res_out.ready) res_v_q <= 1'b0;
			else if (st_q == BK_DONE && !res_v_q) res_v_q <= 1'b1;
		end
	end

	// job registers
	always_ff @(posedge clk) begin
		if (start) begin
			span_q    <= span_c;
			k1_q      <= '0;
			k2_q      <= '0;
			rd_slot_q <= slot_q;
			rd_col_q  <= col_q;
			col0_q    <= col_q;
			orow_q    <= 10'(r16 - h16);
			ocol_q    <= 10'(c16 - h16);
			last_q    <= (r16 == ht16 - 16'd1) && (c16 == w16 - 16'd1);
		end else if (issue) begin
			if (k2_q == span_q) begin
				k2_q      <= '0;
				k1_q      <= k1_q + TW'(1);
				rd_col_q  <= col0_q;
				rd_slot_q <= (rd_slot_q == '0) ? SW'(K - 1) : rd_slot_q - SW'(1);
			end else begin
				k2_q     <= k2_q + TW'(1);
				rd_col_q <= rd_col_q - CW'(1);
			end
		end
		prod_s2 <= pix_s1 * (cok_s1 ? coef_s1 : 16'sd0);
		if (start) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + 40'(prod_s2);
		if (st_q == BK_DONE && !res_v_q) begin
			res_q.out_row    <= orow_q;
			res_q.out_col    <= ocol_q;
			res_q.value      <= acc_q;
			res_q.frame_last <= last_q;
		end
	end

	assign res_out.valid = res_v_q;
	assign res_out.item  = res_q;
endmodule
`default_nettype wire

@@ hdl/sliding_window_2d_convolution.sv @@
// top level of the sliding-window 2d convolution block
// depends on cv2d_pkg, cv2d_if, cv2d_front, cv2d_queue, cv2d_back
//
// channel   dir  payload                                         accepted when
// pix_in    in   operation, coef_row, coef_col, coef_value, pixel  valid & ready
// res_out   out  out_row, out_col, value, frame_last              valid & ready
// cfg       in   index, wdata                                    valid & ready (ready is 1)
//
// a coefficient load or a border pixel is only written to its store by the back end
// an interior pixel is popped, then runs (2*half+1)^2 kernel taps, one per cycle on the shared
// multiplier, then passes the multiply and accumulate registers and the result load
// reset clears counters, coefficient valid bits and the queue; the line store is not cleared
// a full result register stalls the back end; the two-entry queue lets the front keep taking
`default_nettype none
module sliding_window_2d_convolution #(
	parameter int unsigned MAX_KERNEL_SIZE  = 9,
	parameter int unsigned MAX_IMAGE_WIDTH  = 1024,
	parameter int unsigned MAX_IMAGE_HEIGHT = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cv2d_in_if.sink    pix_in,
	cv2d_out_if.source res_out,
	cv2d_cfg_if.sink   cfg
);
	import cv2d_pkg::*;

	// front to queue
	logic q_push;
	logic q_ready;
	job_t q_job;

	// queue to back
	logic q_pop;
	logic q_valid;
	job_t q_head;

	cfg_t cfg_regs;

	// intake, configuration, classification
	cv2d_front #(
		.MAX_KERNEL_SIZE(MAX_KERNEL_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in),
		.cfg(cfg),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_job(q_job),
		.cfg_regs(cfg_regs)
	);

	// decoupling queue
	cv2d_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(q_job),
		.ready(q_ready),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	// stores, tap sequencer and multiply-accumulate
	cv2d_back #(
		.MAX_KERNEL_SIZE(MAX_KERNEL_SIZE),
		.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_regs),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.res_out(res_out)
	);

	// a request enters the queue only from an accepted input
	a_push_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (pix_in.valid && pix_in.ready))
		else $error("queue push without accepted request");

	// the back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// a request pushed while the queue is full would be lost
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("push into full queue");
endmodule
`default_nettype wire

@@ bench/tb_sliding_window_2d_convolution.sv @@
// self-checking testbench for the sliding-window 2d convolution block
// depends on cv2d_pkg, cv2d_if and the rtl under hdl; a built-in predictor checks every result
`default_nettype none
module tb_sliding_window_2d_convolution;
	timeunit 1ns;
	timeprecision 1ps;
	import cv2d_pkg::*;

	localparam int KMAX = 9;
	localparam int WMAX = 1024;
	localparam int HMAX = 1024;
	// an interior pixel costs up to 81 taps plus the multiply-accumulate pipeline and result load
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 2500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cv2d_in_if  pix_in ();
	cv2d_out_if res_out ();
	cv2d_cfg_if cfg ();

	sliding_window_2d_convolution DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.res_out(res_out),
		.cfg    (cfg)
	);

	// predictor state: mirror of the line buffers, kernel, registers and raster position
	logic signed [15:0] ls_mirror [KMAX][WMAX];
	logic signed [15:0] kernel_mirror [KMAX][KMAX];
	logic [2:0]  half_reg;
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	int unsigned row_pos;
	int unsigned col_pos;

	in_item_t  request_q [$];   // requests waiting for the driver
	out_item_t filtered_q [$];  // filtered pixels still to come out
	int unsigned mismatches = 0;

	// test-sequence controls; calm and hold_req are written only by the stimulus process
	bit calm = 1'b0;            // no idling on either side
	int unsigned hold_req = 0;  // bump to make the receiver hold off
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// apply one accepted request to the mirror; a completed window queues its filtered pixel
	task automatic filter_request(input in_item_t req);
		int unsigned h, w, ht, span;
		longint acc;
		out_item_t res;
		if (req.operation == OP_COEF) begin
			// loads outside the 9x9 store are dropped
			if (req.coef_row < KMAX && req.coef_col < KMAX)
				kernel_mirror[req.coef_row][req.coef_col] = req.coef_value;
			return;
		end
		h = clamp(half_reg, 1, (KMAX - 1) / 2);
		w = clamp(width_reg, 1, WMAX);
		ht = clamp(height_reg, 1, HMAX);
		span = 2 * h;
		ls_mirror[row_pos % KMAX][col_pos] = req.pixel;
		// positions left beyond a shrunk size store the pixel but produce nothing
		if (row_pos >= span && col_pos >= span && row_pos < ht && col_pos < w) begin
			acc = 0;
			// flipped kernel: tap (k1,k2) meets the sample k1 rows and k2 columns back
			for (int k1 = 0; k1 <= span; k1++)
				for (int k2 = 0; k2 <= span; k2++)
					acc += longint'(ls_mirror[(row_pos - k1) % KMAX][col_pos - k2]) *
						longint'(kernel_mirror[k1][k2]);
			res.out_row = 10'(row_pos - h);
			res.out_col = 10'(col_pos - h);
			res.value = 40'(acc);
			res.frame_last = (row_pos == ht - 1) && (col_pos == w - 1);
			filtered_q.push_back(res);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= ht)
				row_pos = 0;
		end
	endtask

	// driver: offers queued requests, idles at random, keeps valid up until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
		end else begin
			if (pix_in.valid && pix_in.ready)
				filter_request(pix_in.item);
			if (!pix_in.valid || pix_in.ready) begin
				if (request_q.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
					pix_in.item <= request_q.pop_front();
					pix_in.valid <= 1'b1;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each filtered pixel against the oldest prediction, throttles ready
	always @(posedge clk) begin
		out_item_t want;
		if (res_out.valid && res_out.ready && arst_n) begin
			if (filtered_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0d col %0d",
					res_out.item.out_row, res_out.item.out_col));
			end else begin
				want = filtered_q.pop_front();
				if (res_out.item.out_row !== want.out_row)
					report_mismatch($sformatf("out_row %0d, want %0d",
						res_out.item.out_row, want.out_row));
				if (res_out.item.out_col !== want.out_col)
					report_mismatch($sformatf("out_col %0d, want %0d",
						res_out.item.out_col, want.out_col));
				if (res_out.item.value !== want.value)
					report_mismatch($sformatf("value %0d, want %0d at (%0d,%0d)",
						res_out.item.value, want.value, want.out_row, want.out_col));
				if (res_out.item.frame_last !== want.frame_last)
					report_mismatch($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
						res_out.item.frame_last, want.frame_last, want.out_row, want.out_col));
			end
		end
		// a long hold-off lets the block back up into its input
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			res_out.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_out.ready <= 1'b0;
		end else begin
			res_out.ready <= calm || ($urandom_range(99) >= 29);
		end
	end

	// register write; the block must be idle
	task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_KERNEL_HALF:  half_reg = data[2:0];
			CFG_IMAGE_WIDTH:  width_reg = data;
			CFG_IMAGE_HEIGHT: height_reg = data;
			default: ;
		endcase
		cfg.valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [2:0] h, input logic [10:0] w, input logic [10:0] ht);
		write_reg(CFG_KERNEL_HALF, 11'(h));
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, ht);
	endtask

	// sender pause: nothing pending, nothing in flight, then let the back end finish
	task automatic drain();
		while (request_q.size() > 0 || pix_in.valid || filtered_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t coef_req(input logic [3:0] r, input logic [3:0] c,
			input logic [15:0] v);
		in_item_t it;
		it.operation = OP_COEF;
		it.coef_row = r;
		it.coef_col = c;
		it.coef_value = v;
		it.pixel = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t pixel_req(input logic [15:0] p);
		in_item_t it;
		it.operation = OP_PIXEL;
		it.coef_row = 4'($urandom);
		it.coef_col = 4'($urandom);
		it.coef_value = 16'($urandom);
		it.pixel = p;
		return it;
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// one whole frame for the current geometry, optionally sprinkled with kernel updates
	task automatic queue_frame(input bit mix_coefs);
		int unsigned n;
		n = clamp(width_reg, 1, WMAX) * clamp(height_reg, 1, HMAX);
		for (int unsigned k = 0; k < n; k++) begin
			if (mix_coefs && $urandom_range(19) == 0)
				request_q.push_back(coef_req(4'($urandom_range(8)), 4'($urandom_range(8)),
					16'($urandom)));
			request_q.push_back(pixel_req(rand_sample()));
		end
	endtask

	task automatic queue_kernel(input int unsigned loads);
		for (int unsigned k = 0; k < loads; k++) begin
			// a few loads aim outside the store and must be dropped
			if ($urandom_range(9) == 0)
				request_q.push_back(coef_req(4'($urandom_range(9, 15)), 4'($urandom),
					16'($urandom)));
			else
				request_q.push_back(coef_req(4'($urandom_range(8)), 4'($urandom_range(8)),
					rand_sample()));
		end
	endtask

	initial begin
		int unsigned sent;
		logic [2:0] h;
		// known values on every input before reset is released
		pix_in.valid = 1'b0;
		pix_in.item = '0;
		res_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_KERNEL_HALF;
		cfg.wdata = '0;
		for (int a = 0; a < KMAX; a++)
			for (int b = 0; b < KMAX; b++)
				kernel_mirror[a][b] = '0;
		half_reg = 3'd1;
		width_reg = 11'd1024;
		height_reg = 11'd1024;
		row_pos = 0;
		col_pos = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: half below range acts as 1, extreme coefficients, dropped loads
		set_geometry(3'd0, 11'd3, 11'd3);
		request_q.push_back(coef_req(4'd0, 4'd0, 16'h7fff));
		request_q.push_back(coef_req(4'd1, 4'd1, 16'h8000));
		request_q.push_back(coef_req(4'd2, 4'd2, 16'h0001));
		request_q.push_back(coef_req(4'd15, 4'd15, 16'h7fff));
		request_q.push_back(coef_req(4'd9, 4'd0, 16'hffff));
		request_q.push_back(coef_req(4'd0, 4'd9, 16'hffff));
		request_q.push_back(coef_req(4'd8, 4'd8, 16'h8000));
		for (int k = 0; k < 9; k++)
			request_q.push_back(pixel_req(k[0] ? 16'h8000 : 16'h7fff));
		drain();

		// directed: shrink the image while the raster position sits past the new size
		set_geometry(3'd1, 11'd4, 11'd4);
		for (int k = 0; k < 6; k++)
			request_q.push_back(pixel_req(rand_sample()));
		drain();
		set_geometry(3'd1, 11'd2, 11'd1);
		request_q.push_back(pixel_req(16'h1234));  // stored, no result, wraps to frame start
		drain();

		// register extremes: half above range, width past the maximum, height zero
		set_geometry(3'd7, 11'd9, 11'd9);
		queue_kernel(40);
		queue_frame(1'b0);
		drain();
		set_geometry(3'd4, 11'd0, 11'd0);   // one pixel frame, smaller than any kernel
		queue_frame(1'b0);
		drain();
		set_geometry(3'd5, 11'd2047, 11'd0); // one row, clamped to the full width
		queue_frame(1'b0);
		drain();

		// random frames; one phase runs with no idling, one with a long receiver hold-off
		sent = 0;
		for (int ph = 0; sent < 450 || ph < 4; ph++) begin
			h = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 2)) : 3'($urandom);
			set_geometry(h, 11'($urandom_range(3, 16)), 11'($urandom_range(3, 12)));
			calm = (ph == 3);
			if (ph == 2)
				hold_req++;
			queue_kernel($urandom_range(2, 20));
			queue_frame(1'b1);
			if ($urandom_range(2) == 0)
				queue_frame(1'b1);
			sent = sent + request_q.size();
			drain();
			calm = 1'b0;
		end

		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
